@@ src/mbrot_pkg.sv @@
// Shared types and constants for the Mandelbrot escape magnitude block.
package mbrot_pkg;

    // Default number of fraction bits of c and z.
    localparam int FRAC_BITS_DEF = 29;

    // Fraction bits of the reported magnitude (unsigned Q4.28).
    localparam int MAG_FRAC = 28;

    // Width of the iteration limit register and its value after reset.
    localparam int ITER_W = 10;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(100);

    // Width of the square root result and of its radicand.
    localparam int ROOT_W = 32;
    localparam int RAD_W  = 2 * ROOT_W;

    // Register word index of the configuration port.
    localparam logic REG_MAX_ITER = 1'b0;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MRI,
        S_UPD,
        S_SQR,
        S_SQI,
        S_PREP,
        S_ROOT,
        S_OUT
    } state_t;

endpackage

@@ src/mandelbrot_escape_magnitude_top.sv @@
// Each z*z+c round steps through the states MRI, UPD, SQR and SQI on one shared multiplier;
// then come the final round check, the radicand setup, a 32-step square root and the result load.
// One point is in work at a time: a new point is taken only after the result of the last
// one has been loaded into the output register, which can wait on m_tready.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops the pending result
// and sets the iteration limit to 100; no memory needs clearing.
module mandelbrot_escape_magnitude_top #(
    parameter int FRAC_BITS = mbrot_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] c_re, [63:32] c_im
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] magnitude
    output logic        m_tuser    // [0] escaped
);

    // Magnitude of z after a round stays below 2^(MB+2), MB = max(FRAC_BITS+2, 31).
    localparam int MB = (FRAC_BITS + 2 > 31) ? FRAC_BITS + 2 : 31;
    localparam int MW = MB + 2;          // unsigned magnitude bits of z
    localparam int ZW = MW + 1;          // signed z component bits
    localparam int PW = 2 * MW;          // product bits
    localparam int SW = PW + 1;          // sum of squares bits, also signed difference bits
    localparam int SH_L = (2 * FRAC_BITS <= 2 * mbrot_pkg::MAG_FRAC) ?
                          2 * mbrot_pkg::MAG_FRAC - 2 * FRAC_BITS : 0;
    localparam int SH_R = (2 * FRAC_BITS > 2 * mbrot_pkg::MAG_FRAC) ?
                          2 * FRAC_BITS - 2 * mbrot_pkg::MAG_FRAC : 0;
    localparam int TW = SW + SH_L;       // scaled radicand before the saturation check
    localparam int RW = mbrot_pkg::ROOT_W + 3;
    localparam int STEP_W = $clog2(mbrot_pkg::ROOT_W);

    localparam logic [SW-1:0] LIMIT   = {{(SW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);
    localparam logic [SW-1:0] HALF_RE = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [SW-1:0] HALF_IM = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 2);
    localparam logic [MW-1:0] Z_BOUND = {{(MW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mbrot_pkg::ROOT_W - 1);

    mbrot_pkg::state_t state_reg, state_next;

    logic [mbrot_pkg::ITER_W-1:0] max_iter_reg;
    logic [mbrot_pkg::ITER_W-1:0] iter_cnt_reg;
    logic signed [31:0]           c_re_reg, c_im_reg;
    logic signed [ZW-1:0]         re_reg, im_reg;
    logic [PW-1:0]                sq_re_reg, sq_im_reg, prod_reg;
    logic                         neg_reg;
    logic                         esc_reg;
    logic                         sat_reg;
    logic [mbrot_pkg::RAD_W-1:0]  rad_reg;
    logic [RW-1:0]                rem_reg;
    logic [mbrot_pkg::ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0]            step_reg;
    logic                         out_valid_reg;
    logic                         out_esc_reg;
    logic [31:0]                  out_mag_reg;

    logic [ZW-1:0]   abs_re_full, abs_im_full;
    logic [MW-1:0]   abs_re, abs_im;
    logic [MW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   mul_p;
    logic [SW-1:0]   sum_sq;
    logic            over_limit;
    logic            iter_done;
    logic            out_load;
    logic signed [SW-1:0] diff_s, prod_s, diff_rnd, prod_rnd;
    logic signed [ZW-1:0] new_re, new_im;
    logic [TW-1:0]   scaled;
    logic [RW-1:0]   rem_sh, trial;
    logic            root_fits;
    logic            cfg_write;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == mbrot_pkg::REG_MAX_ITER);
    assign prdata    = (paddr[2] == mbrot_pkg::REG_MAX_ITER) ?
                       {{(32 - mbrot_pkg::ITER_W){1'b0}}, max_iter_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= mbrot_pkg::MAX_ITER_RESET;
        end else if (cfg_write) begin
            max_iter_reg <= pwdata[mbrot_pkg::ITER_W-1:0];
        end
    end

    // Magnitudes of the z components feed the unsigned multiplier.
    assign abs_re_full = re_reg[ZW-1] ? (~re_reg + 1'b1) : re_reg;
    assign abs_im_full = im_reg[ZW-1] ? (~im_reg + 1'b1) : im_reg;
    assign abs_re      = abs_re_full[MW-1:0];
    assign abs_im      = abs_im_full[MW-1:0];

    // The shared multiplier, MW by MW bits with a full width product.
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Exact sum of squares of the current z and the escape test against 4.
    assign sum_sq     = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign over_limit = sum_sq > LIMIT;
    assign iter_done  = iter_cnt_reg == max_iter_reg;

    // Next z: scale the double width terms back with round half up and add c.
    always_comb begin
        diff_s   = $signed({1'b0, sq_re_reg}) - $signed({1'b0, sq_im_reg});
        prod_s   = neg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
        diff_rnd = (diff_s + $signed(HALF_RE)) >>> FRAC_BITS;
        prod_rnd = (prod_s + $signed(HALF_IM)) >>> (FRAC_BITS - 1);
        new_re   = $signed(diff_rnd[ZW-1:0]) + $signed({{(ZW-32){c_re_reg[31]}}, c_re_reg});
        new_im   = $signed(prod_rnd[ZW-1:0]) + $signed({{(ZW-32){c_im_reg[31]}}, c_im_reg});
    end

    // Radicand brought to 56 fraction bits; anything at or above 2^64 saturates.
    assign scaled = (TW'(sum_sq) << SH_L) >> SH_R;

    // One root bit per step: bring down two radicand bits and try to subtract.
    assign rem_sh    = {rem_reg[RW-3:0], rad_reg[mbrot_pkg::RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_fits = rem_sh >= trial;

    // Sequencer: next state, handshake and multiplier operand selection.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        mul_a      = abs_re;
        mul_b      = abs_im;
        case (state_reg)
            mbrot_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = mbrot_pkg::S_MRI;
                end
            end
            mbrot_pkg::S_MRI: begin
                if (over_limit || iter_done) begin
                    state_next = mbrot_pkg::S_PREP;
                end else begin
                    state_next = mbrot_pkg::S_UPD;
                end
            end
            mbrot_pkg::S_UPD: begin
                state_next = mbrot_pkg::S_SQR;
            end
            mbrot_pkg::S_SQR: begin
                mul_b      = abs_re;
                state_next = mbrot_pkg::S_SQI;
            end
            mbrot_pkg::S_SQI: begin
                mul_a      = abs_im;
                state_next = mbrot_pkg::S_MRI;
            end
            mbrot_pkg::S_PREP: begin
                state_next = mbrot_pkg::S_ROOT;
            end
            mbrot_pkg::S_ROOT: begin
                if (step_reg == LAST_STEP) begin
                    state_next = mbrot_pkg::S_OUT;
                end
            end
            mbrot_pkg::S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = mbrot_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mbrot_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbrot_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control counters and the escape flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_cnt_reg <= '0;
            esc_reg      <= 1'b0;
            step_reg     <= '0;
        end else begin
            case (state_reg)
                mbrot_pkg::S_IDLE: begin
                    iter_cnt_reg <= '0;
                    esc_reg      <= 1'b0;
                end
                mbrot_pkg::S_MRI: begin
                    esc_reg <= over_limit;
                end
                mbrot_pkg::S_UPD: begin
                    iter_cnt_reg <= iter_cnt_reg + 1'b1;
                end
                mbrot_pkg::S_PREP: begin
                    step_reg <= '0;
                end
                mbrot_pkg::S_ROOT: begin
                    step_reg <= step_reg + 1'b1;
                end
                default: begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // Datapath registers for z, the products and the square root.
    always_ff @(posedge aclk) begin
        case (state_reg)
            mbrot_pkg::S_IDLE: begin
                c_re_reg  <= $signed(s_tdata[31:0]);
                c_im_reg  <= $signed(s_tdata[63:32]);
                re_reg    <= '0;
                im_reg    <= '0;
                sq_re_reg <= '0;
                sq_im_reg <= '0;
            end
            mbrot_pkg::S_MRI: begin
                prod_reg <= mul_p;
                neg_reg  <= re_reg[ZW-1] ^ im_reg[ZW-1];
            end
            mbrot_pkg::S_UPD: begin
                re_reg <= new_re;
                im_reg <= new_im;
            end
            mbrot_pkg::S_SQR: begin
                prod_reg <= mul_p;
            end
            mbrot_pkg::S_SQI: begin
                sq_re_reg <= prod_reg;
                sq_im_reg <= mul_p;
            end
            mbrot_pkg::S_PREP: begin
                sat_reg  <= |scaled[TW-1:mbrot_pkg::RAD_W];
                rad_reg  <= scaled[mbrot_pkg::RAD_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            mbrot_pkg::S_ROOT: begin
                rad_reg <= rad_reg << 2;
                if (root_fits) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[mbrot_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[mbrot_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            default: begin
                rad_reg <= rad_reg;
            end
        endcase
    end

    // Output register: holds one result until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_esc_reg <= esc_reg;
            out_mag_reg <= sat_reg ? 32'hFFFF_FFFF : root_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mag_reg;
    assign m_tuser  = out_esc_reg;

`ifndef SYNTH
    // A point transfer always starts the round loop.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == mbrot_pkg::S_MRI))
        else $error("round loop not started after input transfer");

    // The round counter never passes the configured limit.
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbrot_pkg::S_MRI) |-> (iter_cnt_reg <= max_iter_reg))
        else $error("round counter past the iteration limit");

    // z enters a round update only with both components within 2 in magnitude.
    a_z_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbrot_pkg::S_UPD) |-> (abs_re <= Z_BOUND && abs_im <= Z_BOUND))
        else $error("z component out of range before a round");

    // An escape needs at least one completed round.
    a_esc_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mbrot_pkg::S_PREP && esc_reg) |-> (iter_cnt_reg != '0))
        else $error("escape flagged without a round");
`endif

endmodule
